[design/tuc_pkg.sv]
package tuc_pkg;

	// UID storage depth: default and legal span of the top-level parameter
	localparam int UID_BYTES_DEF = 10;
	localparam int UID_BYTES_MIN = 4;
	localparam int UID_BYTES_MAX = 10;

	localparam logic [7:0] SAT_MAX = 8'd255;

	// LED pattern codes
	localparam logic [1:0] PAT_OFF     = 2'd0;
	localparam logic [1:0] PAT_SUCCESS = 2'd1;
	localparam logic [1:0] PAT_FAIL    = 2'd2;
	localparam logic [1:0] PAT_LOCKOUT = 2'd3;

	// register indexes on the APB port (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_POLL_PERIOD   = 3'd0,
		REG_MATCH_THR     = 3'd1,
		REG_BLINK_INT     = 3'd2,
		REG_SUCCESS_TOG   = 3'd3,
		REG_FAILURE_TOG   = 3'd4,
		REG_LOCKOUT_THR   = 3'd5,
		REG_LOCKOUT_TIME  = 3'd6
	} reg_idx_t;

	localparam int PADDR_W = 5;

	// reset values of the configuration registers
	localparam logic [15:0] RST_POLL_PERIOD  = 16'd50;
	localparam logic [7:0]  RST_MATCH_THR    = 8'd2;
	localparam logic [15:0] RST_BLINK_INT    = 16'd100;
	localparam logic [7:0]  RST_SUCCESS_TOG  = 8'd6;
	localparam logic [7:0]  RST_FAILURE_TOG  = 8'd6;
	localparam logic [7:0]  RST_LOCKOUT_THR  = 8'd3;
	localparam logic [31:0] RST_LOCKOUT_TIME = 32'd5000;

	typedef struct packed {
		logic [15:0] poll_period_ms;
		logic [7:0]  match_threshold;
		logic [15:0] blink_interval_ms;
		logic [7:0]  success_toggles;
		logic [7:0]  failure_toggles;
		logic [7:0]  lockout_threshold;
		logic [31:0] lockout_time_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        read_ok;
		logic [3:0]  tag_len;
		logic [63:0] tag_bytes_lo;
		logic [15:0] tag_bytes_hi;
	} item_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  led_pattern;
		logic        led_lit;
		logic        success_pulse;
		logic        fail_pulse;
		logic        read_taken;
		logic [63:0] confirmed_lo;
		logic [15:0] confirmed_hi;
		logic [3:0]  confirmed_len;
		logic [7:0]  fail_count;
	} res_t;

endpackage

[design/tuc_cfg.sv]
module tuc_cfg
	import tuc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	reg_idx_t   idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_period_ms    <= RST_POLL_PERIOD;
			cfg_q.match_threshold   <= RST_MATCH_THR;
			cfg_q.blink_interval_ms <= RST_BLINK_INT;
			cfg_q.success_toggles   <= RST_SUCCESS_TOG;
			cfg_q.failure_toggles   <= RST_FAILURE_TOG;
			cfg_q.lockout_threshold <= RST_LOCKOUT_THR;
			cfg_q.lockout_time_ms   <= RST_LOCKOUT_TIME;
		end else if (wr_en) begin
			case (idx)
				REG_POLL_PERIOD:  cfg_q.poll_period_ms    <= pwdata[15:0];
				REG_MATCH_THR:    cfg_q.match_threshold   <= pwdata[7:0];
				REG_BLINK_INT:    cfg_q.blink_interval_ms <= pwdata[15:0];
				REG_SUCCESS_TOG:  cfg_q.success_toggles   <= pwdata[7:0];
				REG_FAILURE_TOG:  cfg_q.failure_toggles   <= pwdata[7:0];
				REG_LOCKOUT_THR:  cfg_q.lockout_threshold <= pwdata[7:0];
				REG_LOCKOUT_TIME: cfg_q.lockout_time_ms   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_POLL_PERIOD:  prdata = {16'd0, cfg_q.poll_period_ms};
			REG_MATCH_THR:    prdata = {24'd0, cfg_q.match_threshold};
			REG_BLINK_INT:    prdata = {16'd0, cfg_q.blink_interval_ms};
			REG_SUCCESS_TOG:  prdata = {24'd0, cfg_q.success_toggles};
			REG_FAILURE_TOG:  prdata = {24'd0, cfg_q.failure_toggles};
			REG_LOCKOUT_THR:  prdata = {24'd0, cfg_q.lockout_threshold};
			REG_LOCKOUT_TIME: prdata = cfg_q.lockout_time_ms;
			default:          prdata = 32'd0;
		endcase
	end

endmodule

[design/tuc_core.sv]
module tuc_core
	import tuc_pkg::*;
#(
	parameter int UID_BYTES = UID_BYTES_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  fire,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	typedef enum logic [2:0] {
		MODE_POLL    = 3'd0,
		MODE_VERIFY  = 3'd1,
		MODE_SUCCESS = 3'd2,
		MODE_FAIL    = 3'd3,
		MODE_REMOVAL = 3'd4,
		MODE_LOCKOUT = 3'd5
	} mode_t;

	typedef logic [UID_BYTES-1:0][7:0] uid_t;

	mode_t       mode_q, mode_d, ent_mode;
	logic [7:0]  match_q, match_d;
	logic [7:0]  streak_q, streak_d;
	logic [7:0]  tog_q, tog_d, tog_val, tog_dec, match_inc;
	logic [31:0] entry_q, entry_d, poll_q, poll_d, blink_q, blink_d;
	logic        led_q, led_d, ent_led;
	logic [1:0]  pat_q, pat_d, ent_pat;
	uid_t        cand_q, cand_d, conf_q, conf_d, rd;
	logic [3:0]  cand_len_q, cand_len_d, conf_len_q, conf_len_d;
	logic [3:0]  len_eff;
	logic [9:0][7:0] tag_all, conf_pad;
	logic        poll_el, blink_el, lock_el, same_uid, blink_done;
	logic        enter, load_cand, set_tog;
	logic        sp, fp, taken;
	logic [31:0] d_poll, d_blink, d_lock;

	// clamp an overlong length, zero bytes at and past it
	assign len_eff = (item.tag_len > 4'(UID_BYTES)) ? 4'(UID_BYTES) : item.tag_len;

	for (genvar i = 0; i < 10; i++) begin : g_tag
		if (i < 8) begin : g_lo
			assign tag_all[i] = item.tag_bytes_lo[8*i +: 8];
		end else begin : g_hi
			assign tag_all[i] = item.tag_bytes_hi[8*(i-8) +: 8];
		end
	end

	for (genvar i = 0; i < UID_BYTES; i++) begin : g_rd
		assign rd[i] = (4'(i) < len_eff) ? tag_all[i] : 8'd0;
	end

	for (genvar i = 0; i < 10; i++) begin : g_conf
		if (i < UID_BYTES) begin : g_used
			assign conf_pad[i] = conf_d[i];
		end else begin : g_pad
			assign conf_pad[i] = 8'd0;
		end
	end

	// 32-bit wrapping elapsed-time checks
	assign d_poll   = item.now_ms - poll_q;
	assign d_blink  = item.now_ms - blink_q;
	assign d_lock   = item.now_ms - entry_q;
	assign poll_el  = d_poll >= {16'd0, cfg.poll_period_ms};
	assign blink_el = d_blink >= {16'd0, cfg.blink_interval_ms};
	assign lock_el  = d_lock >= cfg.lockout_time_ms;

	// stored bytes past the length are zero, so whole-vector compare suffices
	assign same_uid   = (cand_len_q == len_eff) && (cand_q == rd);
	assign tog_dec    = (tog_q != 8'd0) ? tog_q - 8'd1 : 8'd0;
	assign blink_done = (tog_dec == 8'd0);
	assign match_inc  = (match_q < SAT_MAX) ? match_q + 8'd1 : SAT_MAX;

	always_comb begin
		mode_d     = mode_q;
		match_d    = match_q;
		streak_d   = streak_q;
		tog_d      = tog_q;
		entry_d    = entry_q;
		poll_d     = poll_q;
		blink_d    = blink_q;
		led_d      = led_q;
		pat_d      = pat_q;
		cand_d     = cand_q;
		cand_len_d = cand_len_q;
		conf_d     = conf_q;
		conf_len_d = conf_len_q;
		enter      = 1'b0;
		ent_mode   = MODE_POLL;
		ent_pat    = PAT_OFF;
		ent_led    = 1'b0;
		load_cand  = 1'b0;
		set_tog    = 1'b0;
		tog_val    = 8'd0;
		sp         = 1'b0;
		fp         = 1'b0;
		taken      = 1'b0;

		case (mode_q)
			MODE_POLL: begin
				if (poll_el) begin
					poll_d = item.now_ms;
					taken  = 1'b1;
					if (item.read_ok) begin
						enter     = 1'b1;
						ent_mode  = MODE_VERIFY;
						load_cand = 1'b1;
					end
				end
			end
			MODE_VERIFY: begin
				if (poll_el) begin
					poll_d = item.now_ms;
					taken  = 1'b1;
					if (!item.read_ok || !same_uid) begin
						streak_d = (streak_q < SAT_MAX) ? streak_q + 8'd1 : SAT_MAX;
						enter    = 1'b1;
						ent_mode = MODE_FAIL;
						ent_pat  = PAT_FAIL;
						set_tog  = 1'b1;
						tog_val  = cfg.failure_toggles;
						fp       = 1'b1;
					end else begin
						match_d = match_inc;
						if (match_inc >= cfg.match_threshold) begin
							streak_d   = 8'd0;
							mode_d     = MODE_SUCCESS;
							pat_d      = PAT_SUCCESS;
							conf_d     = rd;
							conf_len_d = len_eff;
							tog_d      = cfg.success_toggles;
							entry_d    = item.now_ms;
							blink_d    = item.now_ms;
							led_d      = 1'b0;
							sp         = 1'b1;
						end
					end
				end
			end
			MODE_SUCCESS, MODE_FAIL: begin
				if (blink_el) begin
					blink_d = item.now_ms;
					led_d   = !led_q;
					tog_d   = tog_dec;
					if (blink_done) begin
						led_d = 1'b0;
						enter = 1'b1;
						if (mode_q == MODE_FAIL && streak_q >= cfg.lockout_threshold) begin
							ent_mode = MODE_LOCKOUT;
							ent_pat  = PAT_LOCKOUT;
							ent_led  = 1'b1;
						end else begin
							ent_mode = MODE_REMOVAL;
						end
					end
				end
			end
			MODE_REMOVAL: begin
				if (poll_el) begin
					poll_d = item.now_ms;
					taken  = 1'b1;
					if (!item.read_ok) begin
						enter    = 1'b1;
						ent_mode = MODE_POLL;
					end
				end
			end
			MODE_LOCKOUT: begin
				pat_d = PAT_LOCKOUT;
				led_d = 1'b1;
				if (lock_el) begin
					streak_d = 8'd0;
					enter    = 1'b1;
					ent_mode = MODE_REMOVAL;
				end
			end
			default: begin
				enter    = 1'b1;
				ent_mode = MODE_POLL;
			end
		endcase

		// mode entry: drop the candidate, restart all timestamps
		if (enter) begin
			cand_d     = '0;
			cand_len_d = 4'd0;
			match_d    = 8'd0;
			mode_d     = ent_mode;
			pat_d      = ent_pat;
			tog_d      = 8'd0;
			entry_d    = item.now_ms;
			poll_d     = item.now_ms;
			blink_d    = item.now_ms;
			led_d      = ent_led;
		end
		if (load_cand) begin
			cand_d     = rd;
			cand_len_d = len_eff;
			match_d    = 8'd1;
		end
		if (set_tog) begin
			tog_d = tog_val;
		end
	end

	always_comb begin
		res.mode          = mode_d;
		res.led_pattern   = led_d ? pat_d : PAT_OFF;
		res.led_lit       = led_d;
		res.success_pulse = sp;
		res.fail_pulse    = fp;
		res.read_taken    = taken;
		res.confirmed_lo  = conf_pad[7:0];
		res.confirmed_hi  = conf_pad[9:8];
		res.confirmed_len = conf_len_d;
		res.fail_count    = streak_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_POLL;
			match_q    <= 8'd0;
			streak_q   <= 8'd0;
			tog_q      <= 8'd0;
			entry_q    <= 32'd0;
			poll_q     <= 32'd0;
			blink_q    <= 32'd0;
			led_q      <= 1'b0;
			pat_q      <= PAT_OFF;
			cand_q     <= '0;
			cand_len_q <= 4'd0;
			conf_q     <= '0;
			conf_len_q <= 4'd0;
		end else if (fire) begin
			mode_q     <= mode_d;
			match_q    <= match_d;
			streak_q   <= streak_d;
			tog_q      <= tog_d;
			entry_q    <= entry_d;
			poll_q     <= poll_d;
			blink_q    <= blink_d;
			led_q      <= led_d;
			pat_q      <= pat_d;
			cand_q     <= cand_d;
			cand_len_q <= cand_len_d;
			conf_q     <= conf_d;
			conf_len_q <= conf_len_d;
		end
	end

`ifndef SYNTH
	a_cand_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cand_len_q <= 4'(UID_BYTES))
		else $error("candidate length beyond UID storage");
	a_lock_led: assert property (@(posedge clk) disable iff (!arst_n)
		fire && mode_q == MODE_LOCKOUT && !lock_el |=> led_q)
		else $error("LED dark after a lockout step");
	a_match_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_VERIFY && mode_q != MODE_SUCCESS |-> match_q == 8'd0)
		else $error("match count held outside verify");
`endif

endmodule

[design/tag_uid_confirm_lockout_fsm_top.sv]
// Pipeline: a request waits in the input register, then its result in the result register.
// Throughput: one request per cycle while the result is not stalled; the combinational state update
//   between the two registers sets that figure, and a stalled result stalls the input only once both are full.
// Reset: arst_n clears all mode, counter, timestamp and UID state asynchronously and
//   restores the configuration registers to their defaults; no clearing pass is needed.
module tag_uid_confirm_lockout_fsm_top
	import tuc_pkg::*;
#(
	parameter int UID_BYTES = UID_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        now_ms,
	input  logic               read_ok,
	input  logic [3:0]         tag_len,
	input  logic [63:0]        tag_bytes_lo,
	input  logic [15:0]        tag_bytes_hi,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         mode,
	output logic [1:0]         led_pattern,
	output logic               led_lit,
	output logic               success_pulse,
	output logic               fail_pulse,
	output logic               read_taken,
	output logic [63:0]        confirmed_lo,
	output logic [15:0]        confirmed_hi,
	output logic [3:0]         confirmed_len,
	output logic [7:0]         fail_count
);

	cfg_t  cfg;
	item_t item_s1;
	logic  in_valid_s1;
	res_t  res_d, res_s2;
	logic  out_valid_s2;
	logic  fire;
	logic  in_take;

	tuc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Advance the held request into the state update whenever the result
	// register is empty or being drained this cycle.
	assign fire     = in_valid_s1 && (!out_valid_s2 || !out_stall);
	// Stall only while the input register holds a request that cannot advance.
	assign in_stall = in_valid_s1 && !fire;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (fire) begin
			in_valid_s1 <= 1'b0;
		end
	end

	// Capture the request payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.now_ms       <= now_ms;
			item_s1.read_ok      <= read_ok;
			item_s1.tag_len      <= tag_len;
			item_s1.tag_bytes_lo <= tag_bytes_lo;
			item_s1.tag_bytes_hi <= tag_bytes_hi;
		end
	end

	tuc_core #(
		.UID_BYTES (UID_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Result register: load on fire, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (fire) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = out_valid_s2;
	assign mode          = res_s2.mode;
	assign led_pattern   = res_s2.led_pattern;
	assign led_lit       = res_s2.led_lit;
	assign success_pulse = res_s2.success_pulse;
	assign fail_pulse    = res_s2.fail_pulse;
	assign read_taken    = res_s2.read_taken;
	assign confirmed_lo  = res_s2.confirmed_lo;
	assign confirmed_hi  = res_s2.confirmed_hi;
	assign confirmed_len = res_s2.confirmed_len;
	assign fail_count    = res_s2.fail_count;

`ifndef SYNTH
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(res_s2.success_pulse && res_s2.fail_pulse))
		else $error("success and fail pulse in one result");
	a_pulse_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && (res_s2.success_pulse || res_s2.fail_pulse) |-> res_s2.read_taken)
		else $error("event pulse without a sampled read");
	a_led_dark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && !res_s2.led_lit |-> res_s2.led_pattern == PAT_OFF)
		else $error("pattern shown with LED off");
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1 && out_valid_s2 && out_stall)
		else $error("request stalled with room downstream");
`endif

endmodule

[test/testbench.sv]
module testbench;
	import tuc_pkg::*;

	// Mode codes as the block reports them on the mode output
	typedef enum logic [2:0] {
		MODE_POLL    = 3'd0,
		MODE_VERIFY  = 3'd1,
		MODE_SUCCESS = 3'd2,
		MODE_FAIL    = 3'd3,
		MODE_REMOVAL = 3'd4,
		MODE_LOCKOUT = 3'd5
	} fsm_mode_t;

	localparam int UID_W = 8 * UID_BYTES_DEF;

	// Clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	// APB configuration port, idle from time zero
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// Request channel, driven to known values from the start
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] now_ms = '0;
	logic        read_ok = 1'b0;
	logic [3:0]  tag_len = '0;
	logic [63:0] tag_bytes_lo = '0;
	logic [15:0] tag_bytes_hi = '0;

	// Result channel
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  mode;
	logic [1:0]  led_pattern;
	logic        led_lit;
	logic        success_pulse;
	logic        fail_pulse;
	logic        read_taken;
	logic [63:0] confirmed_lo;
	logic [15:0] confirmed_hi;
	logic [3:0]  confirmed_len;
	logic [7:0]  fail_count;

	tag_uid_confirm_lockout_fsm_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.read_ok      (read_ok),
		.tag_len      (tag_len),
		.tag_bytes_lo (tag_bytes_lo),
		.tag_bytes_hi (tag_bytes_hi),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mode         (mode),
		.led_pattern  (led_pattern),
		.led_lit      (led_lit),
		.success_pulse(success_pulse),
		.fail_pulse   (fail_pulse),
		.read_taken   (read_taken),
		.confirmed_lo (confirmed_lo),
		.confirmed_hi (confirmed_hi),
		.confirmed_len(confirmed_len),
		.fail_count   (fail_count)
	);

	// Requests waiting to be driven, and the status each accepted request must produce
	item_t req_q[$];
	res_t  status_q[$];
	item_t held_req;
	int    mismatch_count = 0;

	// Predictor copy of the configuration and of the lockout state machine
	cfg_t        live_cfg;
	fsm_mode_t   fsm_mode;
	logic [7:0]  match_cnt;
	logic [7:0]  fail_streak;
	logic [7:0]  toggles_left;
	logic [31:0] entry_ms;
	logic [31:0] poll_ms;
	logic [31:0] blink_ms;
	logic        led_on;
	logic [1:0]  led_pat;
	logic [UID_W-1:0] cand_uid;
	logic [3:0]  cand_len;
	logic [UID_W-1:0] conf_uid;
	logic [3:0]  conf_len;

	// Stimulus generator state: the tag that sits on the reader and for how long
	logic [31:0]      gen_now = '0;
	logic             tag_present = 1'b0;
	logic [UID_W-1:0] tag_uid = '0;
	logic [3:0]       tag_size = 4'd4;
	int               hold_left = 0;

	// Sender burst/gap and receiver stall pattern state
	int burst_left = 0;
	int gap_left = 0;
	int stall_left = 0;
	int stall_pct = 0;

	// Wrapping 32-bit elapsed-time test
	function automatic logic window_open(logic [31:0] now, logic [31:0] base,
			logic [31:0] period);
		logic [31:0] diff;
		diff = now - base;
		return diff >= period;
	endfunction

	function automatic logic [7:0] bump_sat(logic [7:0] v);
		return (v == SAT_MAX) ? v : v + 8'd1;
	endfunction

	// Switch mode: drop the candidate, restart all timestamps at now
	function automatic void enter_mode(fsm_mode_t m, logic [1:0] pat, logic led,
			logic [31:0] now);
		cand_uid = '0;
		cand_len = '0;
		match_cnt = '0;
		fsm_mode = m;
		led_pat = pat;
		toggles_left = '0;
		entry_ms = now;
		poll_ms = now;
		blink_ms = now;
		led_on = led;
	endfunction

	// Toggle the LED once per blink interval; report when the toggle budget runs out
	function automatic logic blink_done(logic [31:0] now);
		if (!window_open(now, blink_ms, 32'(live_cfg.blink_interval_ms)))
			return 1'b0;
		blink_ms = now;
		led_on = !led_on;
		if (toggles_left != 0)
			toggles_left--;
		if (toggles_left == 0) begin
			led_on = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void reset_predictor();
		live_cfg.poll_period_ms = RST_POLL_PERIOD;
		live_cfg.match_threshold = RST_MATCH_THR;
		live_cfg.blink_interval_ms = RST_BLINK_INT;
		live_cfg.success_toggles = RST_SUCCESS_TOG;
		live_cfg.failure_toggles = RST_FAILURE_TOG;
		live_cfg.lockout_threshold = RST_LOCKOUT_THR;
		live_cfg.lockout_time_ms = RST_LOCKOUT_TIME;
		enter_mode(MODE_POLL, PAT_OFF, 1'b0, '0);
		fail_streak = '0;
		conf_uid = '0;
		conf_len = '0;
	endfunction

	// Advance the lockout state machine by one request and return the status it shows
	function automatic res_t advance_lockout_fsm(item_t rq);
		res_t             r;
		logic [3:0]       len;
		logic [UID_W-1:0] uid;
		logic             took;
		logic             conf_pulse;
		logic             fail_hit;
		took = 1'b0;
		conf_pulse = 1'b0;
		fail_hit = 1'b0;
		len = (rq.tag_len > UID_BYTES_DEF) ? 4'(UID_BYTES_DEF) : rq.tag_len;
		uid = {rq.tag_bytes_hi, rq.tag_bytes_lo};
		for (int i = 0; i < UID_BYTES_DEF; i++)
			if (i >= len)
				uid[8*i +: 8] = 8'h00;

		case (fsm_mode)
			MODE_POLL: begin
				if (window_open(rq.now_ms, poll_ms, 32'(live_cfg.poll_period_ms))) begin
					poll_ms = rq.now_ms;
					took = 1'b1;
					if (rq.read_ok) begin
						enter_mode(MODE_VERIFY, PAT_OFF, 1'b0, rq.now_ms);
						cand_uid = uid;
						cand_len = len;
						match_cnt = 8'd1;
					end
				end
			end
			MODE_VERIFY: begin
				if (window_open(rq.now_ms, poll_ms, 32'(live_cfg.poll_period_ms))) begin
					poll_ms = rq.now_ms;
					took = 1'b1;
					if (!rq.read_ok || cand_len != len || cand_uid != uid) begin
						fail_streak = bump_sat(fail_streak);
						enter_mode(MODE_FAIL, PAT_FAIL, 1'b0, rq.now_ms);
						toggles_left = live_cfg.failure_toggles;
						fail_hit = 1'b1;
					end else begin
						match_cnt = bump_sat(match_cnt);
						if (match_cnt >= live_cfg.match_threshold) begin
							fail_streak = '0;
							fsm_mode = MODE_SUCCESS;
							led_pat = PAT_SUCCESS;
							conf_uid = uid;
							conf_len = len;
							toggles_left = live_cfg.success_toggles;
							entry_ms = rq.now_ms;
							blink_ms = rq.now_ms;
							led_on = 1'b0;
							conf_pulse = 1'b1;
						end
					end
				end
			end
			MODE_SUCCESS: begin
				if (blink_done(rq.now_ms))
					enter_mode(MODE_REMOVAL, PAT_OFF, 1'b0, rq.now_ms);
			end
			MODE_FAIL: begin
				if (blink_done(rq.now_ms)) begin
					if (fail_streak >= live_cfg.lockout_threshold)
						enter_mode(MODE_LOCKOUT, PAT_LOCKOUT, 1'b1, rq.now_ms);
					else
						enter_mode(MODE_REMOVAL, PAT_OFF, 1'b0, rq.now_ms);
				end
			end
			MODE_REMOVAL: begin
				if (window_open(rq.now_ms, poll_ms, 32'(live_cfg.poll_period_ms))) begin
					poll_ms = rq.now_ms;
					took = 1'b1;
					if (!rq.read_ok)
						enter_mode(MODE_POLL, PAT_OFF, 1'b0, rq.now_ms);
				end
			end
			MODE_LOCKOUT: begin
				led_pat = PAT_LOCKOUT;
				led_on = 1'b1;
				if (window_open(rq.now_ms, entry_ms, live_cfg.lockout_time_ms)) begin
					fail_streak = '0;
					enter_mode(MODE_REMOVAL, PAT_OFF, 1'b0, rq.now_ms);
				end
			end
			default: begin
				enter_mode(MODE_POLL, PAT_OFF, 1'b0, rq.now_ms);
			end
		endcase

		r.mode = fsm_mode;
		r.led_pattern = led_on ? led_pat : PAT_OFF;
		r.led_lit = led_on;
		r.success_pulse = conf_pulse;
		r.fail_pulse = fail_hit;
		r.read_taken = took;
		r.confirmed_lo = conf_uid[63:0];
		r.confirmed_hi = conf_uid[UID_W-1:64];
		r.confirmed_len = conf_len;
		r.fail_count = fail_streak;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] expv, logic [63:0] actv);
		if (expv !== actv) begin
			$error("%s: expected %0h, got %0h", name, expv, actv);
			mismatch_count++;
		end
	endtask

	// Request driver: feed the channel from req_q in bursts separated by idle gaps.
	// A stalled request holds its payload; a new one goes out only once the old is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				status_q.push_back(advance_lockout_fsm(held_req));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0 || req_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					held_req = req_q.pop_front();
					now_ms <= held_req.now_ms;
					read_ok <= held_req.read_ok;
					tag_len <= held_req.tag_len;
					tag_bytes_lo <= held_req.tag_bytes_lo;
					tag_bytes_hi <= held_req.tag_bytes_hi;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// end of burst: pick the next burst and the gap before it
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// Result monitor: check each accepted status against the oldest prediction,
	// and stall the result channel on a pattern of stretches with varying density.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					$error("status arrived with no request outstanding");
					mismatch_count++;
				end else begin
					check_field("mode", status_q[0].mode, mode);
					check_field("led_pattern", status_q[0].led_pattern, led_pattern);
					check_field("led_lit", status_q[0].led_lit, led_lit);
					check_field("success_pulse", status_q[0].success_pulse, success_pulse);
					check_field("fail_pulse", status_q[0].fail_pulse, fail_pulse);
					check_field("read_taken", status_q[0].read_taken, read_taken);
					check_field("confirmed_lo", status_q[0].confirmed_lo, confirmed_lo);
					check_field("confirmed_hi", status_q[0].confirmed_hi, confirmed_hi);
					check_field("confirmed_len", status_q[0].confirmed_len, confirmed_len);
					check_field("fail_count", status_q[0].fail_count, fail_count);
					void'(status_q.pop_front());
				end
			end
			if (stall_left == 0) begin
				// choose the next stretch: free-flowing, light, heavy or solid stall
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 30;
					2: stall_pct = 70;
					default: stall_pct = 100;
				endcase
				stall_left = $urandom_range(1, 30);
			end else begin
				stall_left--;
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Write one register: setup cycle, then access cycle; mirror it in the predictor
	task automatic program_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_POLL_PERIOD:  live_cfg.poll_period_ms = value[15:0];
			REG_MATCH_THR:    live_cfg.match_threshold = value[7:0];
			REG_BLINK_INT:    live_cfg.blink_interval_ms = value[15:0];
			REG_SUCCESS_TOG:  live_cfg.success_toggles = value[7:0];
			REG_FAILURE_TOG:  live_cfg.failure_toggles = value[7:0];
			REG_LOCKOUT_THR:  live_cfg.lockout_threshold = value[7:0];
			REG_LOCKOUT_TIME: live_cfg.lockout_time_ms = value;
			default: ;
		endcase
	endtask

	task automatic load_settings(cfg_t c);
		program_reg(REG_POLL_PERIOD, 32'(c.poll_period_ms));
		program_reg(REG_MATCH_THR, 32'(c.match_threshold));
		program_reg(REG_BLINK_INT, 32'(c.blink_interval_ms));
		program_reg(REG_SUCCESS_TOG, 32'(c.success_toggles));
		program_reg(REG_FAILURE_TOG, 32'(c.failure_toggles));
		program_reg(REG_LOCKOUT_THR, 32'(c.lockout_threshold));
		program_reg(REG_LOCKOUT_TIME, c.lockout_time_ms);
	endtask

	// Hold the sender until every request has been answered, then let the pipe settle
	task automatic wait_drained();
		while (req_q.size() != 0 || in_valid || status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push_req(logic [31:0] t, logic ok, logic [3:0] len,
			logic [63:0] lo, logic [15:0] hi);
		item_t rq;
		rq.now_ms = t;
		rq.read_ok = ok;
		rq.tag_len = len;
		rq.tag_bytes_lo = lo;
		rq.tag_bytes_hi = hi;
		req_q.push_back(rq);
	endtask

	// Random requests: a tag stays on (or off) the reader for a while, so verify
	// sequences run to confirmation; some requests carry a dropped read or a bit error.
	task automatic queue_random_reqs(int count, int max_step);
		item_t            rq;
		logic [UID_W-1:0] data;
		int               eff_len;
		int               noise;
		for (int n = 0; n < count; n++) begin
			if (hold_left == 0) begin
				hold_left = $urandom_range(1, 30);
				tag_present = ($urandom_range(0, 3) != 0);
				if (tag_present && $urandom_range(0, 2) == 0) begin
					tag_uid = UID_W'({$urandom, $urandom, $urandom});
					tag_size = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
						: 4'($urandom_range(4, 10));
				end
			end
			hold_left--;
			// mostly small forward steps; now and then an arbitrary jump
			if ($urandom_range(0, 39) == 0)
				gen_now = gen_now + $urandom;
			else
				gen_now = gen_now + $urandom_range(0, max_step);
			eff_len = (tag_size > UID_BYTES_DEF) ? UID_BYTES_DEF : tag_size;
			// bytes past the length are garbage that the block must ignore
			data = UID_W'({$urandom, $urandom, $urandom});
			for (int i = 0; i < eff_len; i++)
				data[8*i +: 8] = tag_uid[8*i +: 8];
			rq.read_ok = tag_present;
			noise = $urandom_range(0, 19);
			if (noise == 0)
				rq.read_ok = !tag_present;
			else if (noise == 1 && eff_len > 0)
				data[$urandom_range(0, 8*eff_len - 1)] ^= 1'b1;
			rq.now_ms = gen_now;
			rq.tag_len = tag_size;
			rq.tag_bytes_lo = data[63:0];
			rq.tag_bytes_hi = data[UID_W-1:64];
			req_q.push_back(rq);
		end
	endtask

	task automatic run_phase(cfg_t c, int count, int max_step);
		wait_drained();
		load_settings(c);
		@(negedge clk);
		queue_random_reqs(count, max_step);
	endtask

	// Stimulus sequence
	initial begin
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk at reset settings (poll 50, match 2, blink 100, 6 toggles)
		push_req(32'd0, 1'b1, 4'd15, '1, '1);    // poll period not yet elapsed
		push_req(32'd50, 1'b1, 4'd15, '1, '1);   // overlong length, start verify
		push_req(32'd100, 1'b1, 4'd12, '1, '1);  // second match confirms all-ones UID
		for (int k = 2; k < 8; k++)               // six blink toggles, then removal
			push_req(32'(k * 100), 1'b0, 4'd0, '0, '0);
		push_req(32'd749, 1'b0, 4'd0, '0, '0);   // one ms short of the poll period
		push_req(32'd750, 1'b0, 4'd0, '0, '0);   // tag gone, back to polling
		push_req(32'd800, 1'b1, 4'd0, 64'h0123_4567_89AB_CDEF, 16'hABCD); // empty UID
		push_req(32'd850, 1'b0, 4'd0, '0, '0);   // failed read in verify
		for (int k = 0; k < 6; k++)               // fail blink runs out, streak below limit
			push_req(32'(950 + k * 100), 1'b1, 4'd10, '1, '1);
		push_req(32'd1500, 1'b1, 4'd3, '1, '0);  // tag still present, stay in removal
		push_req(32'hFFFF_FFF0, 1'b0, 4'd0, '0, '0);
		push_req(32'h0000_0022, 1'b1, 4'd10, '0, '0);  // poll across the 32-bit wrap
		push_req(32'h0000_0054, 1'b1, 4'd10, '0, '0);  // confirm an all-zero UID

		// Every register at its maximum
		gen_now = 32'h0000_0100;
		run_phase('{poll_period_ms: 16'hFFFF, match_threshold: 8'hFF,
			blink_interval_ms: 16'hFFFF, success_toggles: 8'hFF, failure_toggles: 8'hFF,
			lockout_threshold: 8'hFF, lockout_time_ms: 32'hFFFF_FFFF}, 120, 140000);
		// Every register at zero: immediate confirm, lockout on every fail
		run_phase('{poll_period_ms: 16'd0, match_threshold: 8'd0,
			blink_interval_ms: 16'd0, success_toggles: 8'd0, failure_toggles: 8'd0,
			lockout_threshold: 8'd0, lockout_time_ms: 32'd0}, 250, 5);
		// Short periods, a few matches and quick lockouts
		run_phase('{poll_period_ms: 16'd10, match_threshold: 8'd3,
			blink_interval_ms: 16'd5, success_toggles: 8'd2, failure_toggles: 8'd3,
			lockout_threshold: 8'd2, lockout_time_ms: 32'd40}, 300, 30);
		run_phase('{poll_period_ms: 16'd3, match_threshold: 8'd1,
			blink_interval_ms: 16'd2, success_toggles: 8'd4, failure_toggles: 8'd0,
			lockout_threshold: 8'd1, lockout_time_ms: 32'd9}, 200, 6);
		// Near-default timing, run across the time wrap
		gen_now = 32'hFFFF_F000;
		run_phase('{poll_period_ms: 16'd50, match_threshold: 8'd2,
			blink_interval_ms: 16'd100, success_toggles: 8'd6, failure_toggles: 8'd6,
			lockout_threshold: 8'd3, lockout_time_ms: 32'd400}, 240, 120);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
design/tuc_pkg.sv
design/tuc_cfg.sv
design/tuc_core.sv
design/tag_uid_confirm_lockout_fsm_top.sv
test/testbench.sv
